FILE: design/rkpr_pkg.sv
// Shared types and constants for the remote key press, repeat and release block.
package rkpr_pkg;

  // Raw code layout and the break code
  localparam logic [15:0] BREAK_CODE = 16'h00FF;
  localparam int unsigned KEY_BITS   = 15;
  localparam int unsigned REPEAT_BIT = 15;

  // Event kinds
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_REPEAT  = 2'd2;

  // Operation codes of an input transaction
  localparam logic OP_CODE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_REPEAT_DELAY    = 2'd0;
  localparam logic [1:0] CFG_REPEAT_RATE     = 2'd1;
  localparam logic [1:0] CFG_RELEASE_TIMEOUT = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_REPEAT_DELAY    = 16'd500;
  localparam logic [15:0] RST_REPEAT_RATE     = 16'd100;
  localparam logic [15:0] RST_RELEASE_TIMEOUT = 16'd1500;

  typedef struct packed {
    logic        operation;
    logic [15:0] rc_code;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_code;
    logic [1:0]          event_kind;
    logic                last_of_run;
  } out_item_t;

  // Events produced by one input transaction, in order
  typedef struct packed {
    logic [1:0] num;
    out_item_t  ev0;
    out_item_t  ev1;
  } evt_push_t;

endpackage

FILE: design/rkpr_core.sv
// Key state, repeat and release timers, and event generation for one transaction.
module rkpr_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  rkpr_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output rkpr_pkg::evt_push_t push
);

  localparam logic [32:0] TMAX_W = (33'd1 << TIMER_WIDTH) - 33'd1;
  localparam logic [31:0] TMAX   = TMAX_W[31:0];

  // Saturate a 16-bit load value to the timer width
  function automatic logic [TIMER_WIDTH-1:0] load_val(input logic [15:0] v);
    logic [31:0] wide;
    wide = {16'b0, v};
    if (wide > TMAX) begin
      load_val = TMAX[TIMER_WIDTH-1:0];
    end else begin
      load_val = TIMER_WIDTH'(v);
    end
  endfunction

  logic [15:0] repeat_delay_r, repeat_rate_r, release_timeout_r;

  logic [15:0]            held_code_r, held_code_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [TIMER_WIDTH-1:0] release_count_r, release_count_nxt;
  logic                   release_active_r, release_active_nxt;
  logic [TIMER_WIDTH-1:0] repeat_count_r, repeat_count_nxt;
  logic                   repeat_active_r, repeat_active_nxt;

  logic                   c0_vld, c1_vld;
  rkpr_pkg::out_item_t    c0, c1;
  logic                   differs;
  logic [15:0]            code;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r    <= rkpr_pkg::RST_REPEAT_DELAY;
      repeat_rate_r     <= rkpr_pkg::RST_REPEAT_RATE;
      release_timeout_r <= rkpr_pkg::RST_RELEASE_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        rkpr_pkg::CFG_REPEAT_DELAY:    repeat_delay_r    <= cfg_wdata;
        rkpr_pkg::CFG_REPEAT_RATE:     repeat_rate_r     <= cfg_wdata;
        rkpr_pkg::CFG_RELEASE_TIMEOUT: release_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Compute next key state and the events of this transaction
  always_comb begin
    held_code_nxt      = held_code_r;
    held_valid_nxt     = held_valid_r;
    release_count_nxt  = release_count_r;
    release_active_nxt = release_active_r;
    repeat_count_nxt   = repeat_count_r;
    repeat_active_nxt  = repeat_active_r;
    c0_vld             = 1'b0;
    c1_vld             = 1'b0;
    c0                 = '0;
    c1                 = '0;
    code               = in_item.rc_code;
    differs            = !held_valid_r ||
                         (held_code_r[rkpr_pkg::KEY_BITS-1:0] !=
                          code[rkpr_pkg::KEY_BITS-1:0]);

    if (in_item.operation == rkpr_pkg::OP_CODE) begin
      if (code == rkpr_pkg::BREAK_CODE) begin
        // Break: stop timers, release held key
        release_active_nxt = 1'b0;
        repeat_active_nxt  = 1'b0;
        held_valid_nxt     = 1'b0;
        c0_vld             = held_valid_r;
        c0.key_code        = held_code_r[rkpr_pkg::KEY_BITS-1:0];
        c0.event_kind      = rkpr_pkg::EV_RELEASE;
      end else begin
        release_count_nxt  = load_val(release_timeout_r);
        release_active_nxt = 1'b1;
        held_code_nxt      = code;
        held_valid_nxt     = 1'b1;
        // Release the old key on a new key or a fresh press
        if (held_valid_r && (differs || !code[rkpr_pkg::REPEAT_BIT])) begin
          repeat_active_nxt = 1'b0;
          c0_vld            = 1'b1;
          c0.key_code       = held_code_r[rkpr_pkg::KEY_BITS-1:0];
          c0.event_kind     = rkpr_pkg::EV_RELEASE;
        end
        if (differs) begin
          c1_vld        = 1'b1;
          c1.key_code   = code[rkpr_pkg::KEY_BITS-1:0];
          c1.event_kind = rkpr_pkg::EV_PRESS;
        end else if (code[rkpr_pkg::REPEAT_BIT] && !repeat_active_r) begin
          repeat_count_nxt  = load_val(repeat_delay_r);
          repeat_active_nxt = 1'b1;
        end
      end
    end else begin
      // Tick: advance repeat timer first
      if (repeat_active_r) begin
        if (repeat_count_r <= TIMER_WIDTH'(1)) begin
          c0_vld           = held_valid_r;
          c0.key_code      = held_code_r[rkpr_pkg::KEY_BITS-1:0];
          c0.event_kind    = rkpr_pkg::EV_REPEAT;
          repeat_count_nxt = load_val(repeat_rate_r);
        end else begin
          repeat_count_nxt = repeat_count_r - TIMER_WIDTH'(1);
        end
      end
      // Then the release timer
      if (release_active_r) begin
        if (release_count_r <= TIMER_WIDTH'(1)) begin
          release_active_nxt = 1'b0;
          release_count_nxt  = '0;
          held_valid_nxt     = 1'b0;
          repeat_active_nxt  = 1'b0;
          c1_vld             = held_valid_r;
          c1.key_code        = held_code_r[rkpr_pkg::KEY_BITS-1:0];
          c1.event_kind      = rkpr_pkg::EV_RELEASE;
        end else begin
          release_count_nxt = release_count_r - TIMER_WIDTH'(1);
        end
      end
    end

    // Pack events in order and mark the last one
    c0.last_of_run = !c1_vld;
    c1.last_of_run = 1'b1;
    push.num = {1'b0, c0_vld} + {1'b0, c1_vld};
    push.ev0 = c0_vld ? c0 : c1;
    push.ev1 = c1;
  end

  // Advance key state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_code_r      <= '0;
      held_valid_r     <= 1'b0;
      release_count_r  <= '0;
      release_active_r <= 1'b0;
      repeat_count_r   <= '0;
      repeat_active_r  <= 1'b0;
    end else if (in_fire) begin
      held_code_r      <= held_code_nxt;
      held_valid_r     <= held_valid_nxt;
      release_count_r  <= release_count_nxt;
      release_active_r <= release_active_nxt;
      repeat_count_r   <= repeat_count_nxt;
      repeat_active_r  <= repeat_active_nxt;
    end
  end

endmodule

FILE: design/rkpr_evq.sv
// Four-entry event queue: takes up to two events per cycle, delivers one unless stalled.
module rkpr_evq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_en,
  input  rkpr_pkg::evt_push_t push,
  output logic                full2,
  output logic                out_valid,
  input  logic                out_stall,
  output rkpr_pkg::out_item_t out_item
);

  rkpr_pkg::out_item_t mem_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_in;
  logic       pop;

  // Accept a new transaction only with room for two events
  assign full2     = (count_r > 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_item  = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign n_in      = push_en ? push.num : 2'd0;

  always_comb begin
    tail_nxt  = tail_r + n_in;
    head_nxt  = head_r + {1'b0, pop};
    count_nxt = count_r + {1'b0, n_in} - {2'b0, pop};
  end

  // Write events at the tail
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[tail_r] <= push.ev0;
    end
    if (n_in == 2'd2) begin
      mem_r[tail_r + 2'd1] <= push.ev1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: design/remote_key_press_repeat_release_core.sv
// Top level: remote key event generator with auto-repeat and release timeout.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | rkpr_pkg::in_item_t (operation, rc_code)
//   out_    | output    | valid / stall  | rkpr_pkg::out_item_t (key, kind, last)
//   cfg_    | input     | valid / ready  | 2-bit register index, 16-bit data
//
// One transaction per cycle unless stalled: key state and timers update on acceptance
// and its events enter a four-entry queue, first visible in the next cycle.
// A transaction that yields two events delivers them one at a time; the queue
// stalls the input whenever it cannot hold two more events.
// Reset is synchronous on rst_n; cfg_ready is always high.
module remote_key_press_repeat_release_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rkpr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rkpr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic                in_fire;
  logic                full2;
  rkpr_pkg::evt_push_t push;

  assign in_stall  = full2;
  assign in_fire   = in_valid && !full2;
  assign cfg_ready = 1'b1;

  rkpr_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  rkpr_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_fire),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: sim/tb_remote_key_press_repeat_release_core.sv
// Testbench for the remote key press, repeat and release core with its own event predictor.
`timescale 1ns / 100ps

module tb_remote_key_press_repeat_release_core;

  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam int WATCHDOG_CYCLES       = 2000;
  localparam int SETTLE_CYCLES         = 8;
  localparam int MAX_PRINTED           = 100;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rkpr_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rkpr_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_wdata = '0;

  // Key tracker state and register copies
  logic [15:0] held_code;
  bit          key_held;
  logic [15:0] rel_cnt;
  bit          rel_on;
  logic [15:0] rpt_cnt;
  bit          rpt_on;
  logic [15:0] rpt_delay;
  logic [15:0] rpt_rate;
  logic [15:0] rel_timeout;

  rkpr_pkg::in_item_t  pending_items[$];
  rkpr_pkg::out_item_t expected_events[$];

  int  n_queued  = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_writes  = 0;
  int  errors    = 0;
  int  gap_left  = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  idle_on   = 1'b1;

  remote_key_press_repeat_release_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
  endtask

  task automatic add_event(input logic [15:0] code, input logic [1:0] kind);
    rkpr_pkg::out_item_t ev;
    ev.key_code    = code[rkpr_pkg::KEY_BITS-1:0];
    ev.event_kind  = kind;
    ev.last_of_run = 1'b0;
    expected_events.push_back(ev);
  endtask

  // Drop the held key, stop repeating, report a release if a key was held
  task automatic release_key();
    bit was;
    was      = key_held;
    key_held = 1'b0;
    rpt_on   = 1'b0;
    if (was) add_event(held_code, rkpr_pkg::EV_RELEASE);
  endtask

  // Advance the key tracker by one transaction and queue the events it causes
  task automatic predict_events(input rkpr_pkg::in_item_t it);
    logic [15:0] code;
    logic [15:0] old;
    bit was;
    bit differs;
    int base;
    rkpr_pkg::out_item_t ev;
    base = expected_events.size();
    if (it.operation == rkpr_pkg::OP_CODE) begin
      code = it.rc_code;
      if (code == rkpr_pkg::BREAK_CODE) begin
        rel_on = 1'b0;
        rpt_on = 1'b0;
        release_key();
      end else begin
        was       = key_held;
        old       = held_code;
        rel_cnt   = rel_timeout;
        rel_on    = 1'b1;
        held_code = code;
        key_held  = 1'b1;
        differs   = !was || (old[rkpr_pkg::KEY_BITS-1:0] != code[rkpr_pkg::KEY_BITS-1:0]);
        if (was && (differs || !code[rkpr_pkg::REPEAT_BIT])) begin
          rpt_on = 1'b0;
          add_event(old, rkpr_pkg::EV_RELEASE);
        end
        if (differs) begin
          add_event(code, rkpr_pkg::EV_PRESS);
        end else if (code[rkpr_pkg::REPEAT_BIT] && !rpt_on) begin
          rpt_cnt = rpt_delay;
          rpt_on  = 1'b1;
        end
      end
    end else begin
      // Repeat timer first, then the release timer
      if (rpt_on) begin
        if (rpt_cnt <= 16'd1) begin
          if (key_held) add_event(held_code, rkpr_pkg::EV_REPEAT);
          rpt_cnt = rpt_rate;
        end else begin
          rpt_cnt--;
        end
      end
      if (rel_on) begin
        if (rel_cnt <= 16'd1) begin
          rel_on  = 1'b0;
          rel_cnt = '0;
          release_key();
        end else begin
          rel_cnt--;
        end
      end
    end
    // Mark the final event of this transaction
    if (expected_events.size() > base) begin
      ev = expected_events.pop_back();
      ev.last_of_run = 1'b1;
      expected_events.push_back(ev);
    end
  endtask

  // Driver: hold a stalled transaction, otherwise load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_events(in_item);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted event against the oldest expectation
  always @(posedge clk) begin
    rkpr_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event", int'(out_item), 0);
        end else begin
          want = expected_events.pop_front();
          n_checked++;
          if (out_item.key_code !== want.key_code)
            report_mismatch("key_code", int'(out_item.key_code), int'(want.key_code));
          if (out_item.event_kind !== want.event_kind)
            report_mismatch("event_kind", int'(out_item.event_kind),
                            int'(want.event_kind));
          if (out_item.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", int'(out_item.last_of_run),
                            int'(want.last_of_run));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: no handshake on any channel for far longer than a correct run allows
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout after %0d quiet cycles, %0d events outstanding",
                 quiet_cycles, expected_events.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rkpr_pkg::CFG_REPEAT_DELAY:    rpt_delay = val;
      rkpr_pkg::CFG_REPEAT_RATE:     rpt_rate = val;
      rkpr_pkg::CFG_RELEASE_TIMEOUT: rel_timeout = val;
      default: ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] d, input logic [15:0] r, input logic [15:0] t);
    write_reg(rkpr_pkg::CFG_REPEAT_DELAY, d);
    write_reg(rkpr_pkg::CFG_REPEAT_RATE, r);
    write_reg(rkpr_pkg::CFG_RELEASE_TIMEOUT, t);
    // Unused index must leave every register alone
    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
  endtask

  task automatic queue_code(input logic [15:0] code);
    rkpr_pkg::in_item_t it;
    it.operation = rkpr_pkg::OP_CODE;
    it.rc_code   = code;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Ticks carry random junk in rc_code, which must be ignored
  task automatic queue_ticks(input int n);
    rkpr_pkg::in_item_t it;
    repeat (n) begin
      it.operation = rkpr_pkg::OP_TICK;
      it.rc_code   = 16'($urandom_range(0, 65535));
      pending_items.push_back(it);
      n_queued++;
    end
  endtask

  // Wait until every transaction is taken and every event has arrived
  task automatic settle();
    @(negedge clk);
    while (n_accepted != n_queued || expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [14:0] pick_key();
    case ($urandom_range(0, 7))
      0, 1: pick_key = 15'($urandom_range(0, 32767));
      2: pick_key = 15'h7FFF;
      3: pick_key = 15'h00FF;
      4: pick_key = 15'h0000;
      default: pick_key = 15'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic int tick_span();
    int s;
    s = int'(rpt_delay) + 2;
    if (s > 24) s = 24;
    tick_span = s;
  endfunction

  // Mostly press, hold-with-repeat, release sequences; the rest is noise
  task automatic random_traffic(input int budget);
    int start;
    int reps;
    logic [14:0] key;
    start = n_queued;
    while (n_queued - start < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        key = pick_key();
        queue_code({1'b0, key});
        reps = $urandom_range(0, 5);
        repeat (reps) begin
          queue_ticks($urandom_range(0, tick_span()));
          queue_code({($urandom_range(0, 7) != 0), key});
        end
        queue_ticks($urandom_range(0, tick_span()));
        case ($urandom_range(0, 3))
          0: queue_code(rkpr_pkg::BREAK_CODE);
          1: if (rel_timeout <= 16'd40) queue_ticks(int'(rel_timeout) + 1);
          default: ;  // the next key releases this one
        endcase
      end else if ($urandom_range(0, 1) == 0) begin
        queue_code(16'($urandom_range(0, 65535)));
      end else begin
        queue_ticks($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    held_code   = '0;
    key_held    = 1'b0;
    rel_cnt     = '0;
    rel_on      = 1'b0;
    rpt_cnt     = '0;
    rpt_on      = 1'b0;
    rpt_delay   = rkpr_pkg::RST_REPEAT_DELAY;
    rpt_rate    = rkpr_pkg::RST_REPEAT_RATE;
    rel_timeout = rkpr_pkg::RST_RELEASE_TIMEOUT;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: first repeat after 500 ticks, the next 100 later
    queue_code(16'h0011);
    queue_code(16'h8011);
    queue_ticks(601);
    queue_code(rkpr_pkg::BREAK_CODE);
    settle();

    // Directed cases with short timers
    set_config(16'd3, 16'd2, 16'd6);
    queue_code(16'h0005);          // press
    queue_code(16'h0005);          // same key without repeat flag: release only
    queue_code(16'h8005);          // same key with flag: repeat timer starts
    queue_ticks(3);                // first repeat
    queue_code(16'h8005);          // timer already running
    queue_code(16'h0006);          // other key: release then press
    queue_ticks(7);                // release timeout
    queue_code(rkpr_pkg::BREAK_CODE);  // break with nothing held
    queue_ticks(1);
    queue_code(16'h7FFF);
    queue_code(16'hFFFF);
    queue_ticks(2);
    queue_code(16'h80FF);          // key 0xFF with flag is not a break
    queue_code(rkpr_pkg::BREAK_CODE);
    queue_code(16'h0000);
    queue_code(16'h8007);          // other key carrying the flag
    queue_code(16'h8007);
    queue_code(rkpr_pkg::BREAK_CODE);
    settle();

    // Smallest timers: repeat and release expire on the same tick
    set_config(16'd1, 16'd1, 16'd1);
    queue_code(16'h0005);
    queue_code(16'h8005);
    queue_ticks(2);
    random_traffic(80);
    settle();

    // Largest timers: nothing expires
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic(60);
    settle();

    // Mixed extremes and random small settings
    set_config(16'd1, 16'hFFFF, 16'd20);
    random_traffic(60);
    settle();
    repeat (2) begin
      set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 30)));
      random_traffic(80);
      settle();
    end

    // Last stretch with no idling on either side
    @(negedge clk);
    idle_on = 1'b0;
    set_config(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
               16'($urandom_range(2, 25)));
    random_traffic(100);
    settle();

    $display("ran %0d input transactions and %0d register writes, checked %0d events",
             n_accepted, n_writes, n_checked);
    $display("timer settings from 1 to 65535, mismatches: %0d", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rkpr_pkg.sv
design/rkpr_core.sv
design/rkpr_evq.sv
design/remote_key_press_repeat_release_core.sv
sim/tb_remote_key_press_repeat_release_core.sv
